// File: sv/rbza_pkg.sv
package rbza_pkg;

  // opcodes
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_PUBLISH = 2'd1;
  localparam logic [1:0] OP_GET     = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_RETRY   = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_BADSIZE = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // shared adder functions
  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  localparam int ALU_W = 18;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [16:0] amount;
    logic [15:0] zone_base;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_start;
    logic [16:0] out_size;
    logic [16:0] free_space;
  } out_item_t;

  typedef struct packed {
    logic        pad;
    logic [16:0] size;
    logic [15:0] start;
  } zone_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    logic  rd_en;
    zone_t wdata;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: sv/rbza_alu.sv
module rbza_alu
  import rbza_pkg::*;
(
  input  logic             alu_op,
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  output logic [ALU_W-1:0] y
);

  // sign bit of y flags a < b on subtract (operands stay below 2^17)
  always_comb begin
    if (alu_op == ALU_SUB) begin
      y = a - b;
    end else begin
      y = a + b;
    end
  end

endmodule

// File: sv/rbza_queue.sv
module rbza_queue
  import rbza_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  q_ctl_t  ctl,
  output q_stat_t stat,
  output zone_t   rd_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  zone_t         mem [QUEUE_DEPTH];
  zone_t         rd_data_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.push) begin
      tail_nxt  = (tail_r == LAST) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop) begin
      head_nxt  = (head_r == LAST) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= ctl.wdata;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[head_r];
    end
  end

  assign stat.full  = (count_r == FULL_CNT);
  assign stat.empty = (count_r == '0);
  assign rd_data    = rd_data_r;

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> !stat.full)
    else $error("push into full zone queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> !stat.empty)
    else $error("pop from empty zone queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("zone queue count out of range");

endmodule

// File: sv/ring_buffer_zone_allocator.sv
// Ring buffer zone allocator.
// Command channel: an item (opcode, amount, zone_base) is taken on the
// rising edge where start is high and busy is low. busy then stays high
// until the result is issued. Result channel: out_valid is high for one
// cycle with out_item (status, out_start, out_size, free_space); the
// receiver cannot stall, so it must take the item in that cycle.
// All steps run on one shared 18-bit adder. Publish, release, bad size
// and no space finish in the decode step. Alloc checks the space, finds
// the room to the ring end and compares; it then grants, or queues a
// padding zone, charges it and retries once at offset 0. Get tests the
// queue, reads the head and skips padding zones until it finds a real
// zone or the queue is empty.
// busy drops as the result goes out, so the next item may be accepted on
// the edge that takes the result, and no item is taken before then.
// Zones sit in a QUEUE_DEPTH entry memory with a registered read port.
// Reset (rst_n low, synchronous) empties the queue, sets the write
// position to 0 and marks the whole ring free; queue memory is not
// cleared, entries are only read after being written.
module ring_buffer_zone_allocator
  import rbza_pkg::*;
#(
  parameter int RING_SIZE   = 65536,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam logic [ALU_W-1:0] RING_W = ALU_W'(RING_SIZE);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;  // decode, first step of each op
  localparam logic [3:0] S_A_PAD   = 4'd2;  // room to ring end
  localparam logic [3:0] S_A_CMP   = 4'd3;  // does the request reach the end
  localparam logic [3:0] S_A_GRANT = 4'd4;  // straight grant
  localparam logic [3:0] S_A_WRAP  = 4'd5;  // charge padding, wrap
  localparam logic [3:0] S_A_RETRY = 4'd6;  // one retry at offset 0
  localparam logic [3:0] S_G_CHK   = 4'd7;  // queue empty test, read head
  localparam logic [3:0] S_G_DATA  = 4'd8;  // head zone available

  logic [3:0]  state_r, state_nxt;
  logic [15:0] wp_r, wp_nxt;          // write position
  logic [16:0] free_r, free_nxt;      // free units
  logic [16:0] pad_r, pad_nxt;        // RING_SIZE - write position
  logic [16:0] diff_r, diff_nxt;      // free - amount from the space check
  in_item_t    item_r, item_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  logic             alu_op;
  logic [ALU_W-1:0] alu_a, alu_b, alu_y;
  logic [16:0]      sat_sum;

  q_ctl_t  q_ctl;
  q_stat_t q_stat;
  zone_t   q_rd;

  logic        done;
  logic [2:0]  done_status;
  logic [15:0] done_start;
  logic [16:0] done_size;

  rbza_alu u_alu (
    .alu_op (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .y      (alu_y)
  );

  rbza_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (q_ctl),
    .stat    (q_stat),
    .rd_data (q_rd)
  );

  // release and skipped padding zones saturate at the ring size
  assign sat_sum = (alu_y > RING_W) ? RING_W[16:0] : alu_y[16:0];

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    free_nxt    = free_r;
    pad_nxt     = pad_r;
    diff_nxt    = diff_r;
    item_nxt    = item_r;
    q_ctl       = '0;
    alu_op      = ALU_ADD;
    alu_a       = '0;
    alu_b       = '0;
    done        = 1'b0;
    done_status = ST_OK;
    done_start  = '0;
    done_size   = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        if (item_r.opcode == OP_GET) begin
          state_nxt = S_G_CHK;
          if (q_stat.empty) begin
            done        = 1'b1;
            done_status = ST_EMPTY;
          end else begin
            q_ctl.rd_en = 1'b1;
            state_nxt   = S_G_DATA;
          end
        end else if (item_r.amount == '0) begin
          done        = 1'b1;
          done_status = ST_BADSIZE;
        end else begin
          case (item_r.opcode)
            OP_ALLOC: begin
              alu_op = ALU_SUB;
              alu_a  = {1'b0, free_r};
              alu_b  = {1'b0, item_r.amount};
              if (alu_y[ALU_W-1]) begin
                done        = 1'b1;
                done_status = ST_RETRY;
              end else begin
                diff_nxt  = alu_y[16:0];
                state_nxt = S_A_PAD;
              end
            end
            OP_PUBLISH: begin
              done = 1'b1;
              if (q_stat.full) begin
                done_status = ST_FULL;
              end else begin
                q_ctl.push        = 1'b1;
                q_ctl.wdata.pad   = 1'b0;
                q_ctl.wdata.size  = item_r.amount;
                q_ctl.wdata.start = item_r.zone_base;
                done_start        = item_r.zone_base;
                done_size         = item_r.amount;
              end
            end
            OP_RELEASE: begin
              alu_a    = {1'b0, free_r};
              alu_b    = {1'b0, item_r.amount};
              free_nxt = sat_sum;
              done     = 1'b1;
            end
            default: begin
              done        = 1'b1;
              done_status = ST_BADSIZE;
            end
          endcase
        end
      end

      S_A_PAD: begin
        alu_op    = ALU_SUB;
        alu_a     = RING_W;
        alu_b     = {2'b00, wp_r};
        pad_nxt   = alu_y[16:0];
        state_nxt = S_A_CMP;
      end

      S_A_CMP: begin
        // amount < pad means the zone ends before the ring end
        alu_op = ALU_SUB;
        alu_a  = {1'b0, item_r.amount};
        alu_b  = {1'b0, pad_r};
        if (alu_y[ALU_W-1]) begin
          state_nxt = S_A_GRANT;
        end else if (q_stat.full) begin
          done        = 1'b1;
          done_status = ST_FULL;
        end else begin
          q_ctl.push        = 1'b1;
          q_ctl.wdata.pad   = 1'b1;
          q_ctl.wdata.size  = pad_r;
          q_ctl.wdata.start = wp_r;
          state_nxt         = S_A_WRAP;
        end
      end

      S_A_GRANT: begin
        alu_a      = {2'b00, wp_r};
        alu_b      = {1'b0, item_r.amount};
        wp_nxt     = alu_y[15:0];
        free_nxt   = diff_r;
        done       = 1'b1;
        done_start = wp_r;
        done_size  = item_r.amount;
      end

      S_A_WRAP: begin
        alu_op    = ALU_SUB;
        alu_a     = {1'b0, free_r};
        alu_b     = {1'b0, pad_r};
        free_nxt  = alu_y[16:0];
        wp_nxt    = '0;
        state_nxt = S_A_RETRY;
      end

      S_A_RETRY: begin
        // padding is at least one unit, so a fit here is below RING_SIZE
        alu_op = ALU_SUB;
        alu_a  = {1'b0, free_r};
        alu_b  = {1'b0, item_r.amount};
        done   = 1'b1;
        if (alu_y[ALU_W-1]) begin
          done_status = ST_RETRY;
        end else begin
          wp_nxt    = item_r.amount[15:0];
          free_nxt  = alu_y[16:0];
          done_size = item_r.amount;
        end
      end

      S_G_CHK: begin
        if (q_stat.empty) begin
          done        = 1'b1;
          done_status = ST_EMPTY;
        end else begin
          q_ctl.rd_en = 1'b1;
          state_nxt   = S_G_DATA;
        end
      end

      S_G_DATA: begin
        q_ctl.pop = 1'b1;
        if (q_rd.pad) begin
          alu_a     = {1'b0, free_r};
          alu_b     = {1'b0, q_rd.size};
          free_nxt  = sat_sum;
          state_nxt = S_G_CHK;
        end else begin
          done       = 1'b1;
          done_start = q_rd.start;
          done_size  = q_rd.size;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = done;
    out_item_nxt  = out_item_r;
    if (done) begin
      state_nxt               = S_IDLE;
      out_item_nxt.status     = done_status;
      out_item_nxt.out_start  = done_start;
      out_item_nxt.out_size   = done_size;
      out_item_nxt.free_space = free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      free_r      <= RING_W[16:0];
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scratch, no reset
  always_ff @(posedge clk) begin
    pad_r      <= pad_nxt;
    diff_r     <= diff_nxt;
    item_r     <= item_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result issued while still busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= RING_W[16:0])
    else $error("free units above ring size");

  a_nonok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |->
      (out_item.out_start == '0 && out_item.out_size == '0))
    else $error("failed request carries a zone");

endmodule
